// File: rtl/vrt_pkg.sv
`default_nettype none
package vrt_pkg;
  localparam int GRID_SIZE_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int POS_W = 23;
  localparam int DIR_W = 18;
  localparam int REACH_W = 23;
  localparam logic [REACH_W-1:0] REACH_RESET = 23'd294912;
  localparam int DIST_W = 32;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam int CELL_W = 6;
  localparam int FACE_W = 3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST = 1'b1;

  localparam logic [FACE_W-1:0] FACE_WEST = 3'd0;
  localparam logic [FACE_W-1:0] FACE_EAST = 3'd1;
  localparam logic [FACE_W-1:0] FACE_SOUTH = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NORTH = 3'd3;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd4;
  localparam logic [FACE_W-1:0] FACE_TOP = 3'd5;

  localparam logic [1:0] REG_REACH = 2'd0;

  typedef struct packed {
    logic op;
    logic [CELL_W-1:0] vx;
    logic [CELL_W-1:0] vy;
    logic [CELL_W-1:0] vz;
    logic solid;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic signed [POS_W-1:0] sz;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
    logic signed [DIR_W-1:0] dz;
  } item_t;

  typedef struct packed {
    logic hit;
    logic [CELL_W-1:0] hx;
    logic [CELL_W-1:0] hy;
    logic [CELL_W-1:0] hz;
    logic [FACE_W-1:0] face;
  } result_t;
endpackage
`default_nettype wire

// File: rtl/vrt_if.sv
`default_nettype none
interface vrt_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic [5:0] voxel_x;
  logic [5:0] voxel_y;
  logic [5:0] voxel_z;
  logic solid;
  logic signed [22:0] start_x;
  logic signed [22:0] start_y;
  logic signed [22:0] start_z;
  logic signed [17:0] dir_x;
  logic signed [17:0] dir_y;
  logic signed [17:0] dir_z;
  modport source(output valid, operation, voxel_x, voxel_y, voxel_z, solid,
    start_x, start_y, start_z, dir_x, dir_y, dir_z, input ready);
  modport sink(input valid, operation, voxel_x, voxel_y, voxel_z, solid,
    start_x, start_y, start_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface vrt_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic [5:0] hit_x;
  logic [5:0] hit_y;
  logic [5:0] hit_z;
  logic [2:0] face;
  modport source(output valid, hit, hit_x, hit_y, hit_z, face, input ready);
  modport sink(input valid, hit, hit_x, hit_y, hit_z, face, output ready);
endinterface
`default_nettype wire

// File: rtl/voxel_ray_traversal_unit.sv
`default_nettype none
// channel | dir | payload
// in      | in  | operation, voxel_x/y/z, solid, start_x/y/z, dir_x/y/z
// out     | out | hit, hit_x/y/z, face (one transfer per cast)
// apb     | in  | reach_limit at address 0
// A write goes into the grid as the engine accepts it. A cast is accepted,
// its three reciprocals are found bit-serially (one quotient bit a cycle),
// each visited cell passes read, wait and evaluate states around one
// registered occupancy read, and the result is handed off. After reset a
// clearing pass empties the grid; the queue still takes two items and configuration writes go through meanwhile.
// The result register holds a waiting transfer while the engine works ahead.
module voxel_ray_traversal_unit (
  input wire logic clk,
  input wire logic rst,
  vrt_in_if.sink in_ch,
  vrt_out_if.source out_ch,
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic [1:0] paddr,
  input wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import vrt_pkg::*;
  logic [REACH_W-1:0] reach;
  item_t q_in, q_out;
  logic q_valid, q_ready;
  result_t res;

  assign pready = 1'b1;
  assign prdata = (paddr == {REG_REACH}) ? 32'(reach) : 32'd0;
  // Take the reach register on the access phase of a write.
  always_ff @(posedge clk) begin
    if (rst) begin
      reach <= REACH_RESET;
    end else if (psel && penable && pwrite && paddr == REG_REACH) begin
      reach <= pwdata[REACH_W-1:0];
    end
  end

  assign q_in = '{op: in_ch.operation, vx: in_ch.voxel_x, vy: in_ch.voxel_y,
    vz: in_ch.voxel_z, solid: in_ch.solid, sx: in_ch.start_x, sy: in_ch.start_y,
    sz: in_ch.start_z, dx: in_ch.dir_x, dy: in_ch.dir_y, dz: in_ch.dir_z};

  vrt_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_item(q_in), .out_valid(q_valid), .out_ready(q_ready), .out_item(q_out));

  vrt_engine u_engine (
    .clk(clk), .rst(rst), .reach(reach), .in_valid(q_valid), .in_ready(q_ready),
    .in_item(q_out), .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res));

  assign out_ch.hit = res.hit;
  assign out_ch.hit_x = res.hx;
  assign out_ch.hit_y = res.hy;
  assign out_ch.hit_z = res.hz;
  assign out_ch.face = res.face;
endmodule
`default_nettype wire

// File: rtl/vrt_ram.sv
`default_nettype none
module vrt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/vrt_queue.sv
`default_nettype none
module vrt_queue (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire vrt_pkg::item_t in_item,
  output logic out_valid,
  input wire logic out_ready,
  output vrt_pkg::item_t out_item
);
  import vrt_pkg::*;
  item_t slot [2];
  logic wp, rp;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        wp <= ~wp;
      end
      if (out_valid && out_ready) begin
        rp <= ~rp;
      end
      count <= count + 2'((in_valid && in_ready) ? 1 : 0)
        - 2'((out_valid && out_ready) ? 1 : 0);
    end
    if (in_valid && in_ready) begin
      slot[wp] <= in_item;
    end
  end
endmodule
`default_nettype wire

// File: rtl/vrt_engine.sv
`default_nettype none
module vrt_engine (
  input wire logic clk,
  input wire logic rst,
  input wire logic [vrt_pkg::REACH_W-1:0] reach,
  input wire logic in_valid,
  output logic in_ready,
  input wire vrt_pkg::item_t in_item,
  output logic res_valid,
  input wire logic res_ready,
  output vrt_pkg::result_t res
);
  import vrt_pkg::*;
  localparam int GRID_SIZE = GRID_SIZE_DEF;
  localparam int FRAC_BITS = FRAC_BITS_DEF;
  localparam int GB = $clog2(GRID_SIZE);
  localparam int DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW = 3 * GB;
  localparam int CW = POS_W - FRAC_BITS + 2;
  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int MAGW = DIR_W;
  localparam int PW = DIST_W + FRAC_BITS + 1;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE = 8'b00000010,
    S_DIV = 8'b00000100,
    S_MUL = 8'b00001000,
    S_READ = 8'b00010000,
    S_WAIT = 8'b00100000,
    S_EVAL = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t state;
  logic [AW-1:0] clr_addr;
  logic signed [CW-1:0] c [3];
  logic signed [1:0] stp [3];
  logic [DIST_W-1:0] delta [3];
  logic [DIST_W-1:0] side [3];
  logic [FRAC_BITS:0] bdist [3];
  logic [MAGW-1:0] mag [3];
  logic [1:0] ax;
  logic [QW-1:0] rem, quo;
  logic [$clog2(QW+1)-1:0] bit_cnt;
  logic [FACE_W-1:0] face;
  result_t found;
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic ram_wdata, ram_rdata;

  vrt_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_grid (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata));

  function automatic logic in_range(logic signed [CW-1:0] v);
    return (v >= 0) && (v < CW'(GRID_SIZE));
  endfunction

  logic wr_ok;
  assign wr_ok = (int'(in_item.vx) < GRID_SIZE) && (int'(in_item.vy) < GRID_SIZE)
    && (int'(in_item.vz) < GRID_SIZE);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = 1'b0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
    end else if (in_valid && in_ready && in_item.op == OP_WRITE && wr_ok) begin
      ram_we = 1'b1;
      ram_waddr = {in_item.vz[GB-1:0], in_item.vy[GB-1:0], in_item.vx[GB-1:0]};
      ram_wdata = in_item.solid;
    end
  end
  assign ram_raddr = {c[2][GB-1:0], c[1][GB-1:0], c[0][GB-1:0]};

  logic [QW-1:0] rem_sh;
  logic rem_ge;
  logic [QW-1:0] dividend;
  assign dividend = QW'(1) << (2 * FRAC_BITS);
  assign rem_sh = {rem[QW-2:0], dividend[bit_cnt[$clog2(QW)-1:0]]};
  assign rem_ge = rem_sh >= QW'(mag[ax]);

  logic in_g, leave, take0, take1;
  logic [1:0] sel;
  assign in_g = in_range(c[0]) && in_range(c[1]) && in_range(c[2]);
  always_comb begin
    leave = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ((c[i] < 0 && stp[i] <= 0) || (c[i] >= CW'(GRID_SIZE) && stp[i] >= 0)) begin
        leave = 1'b1;
      end
    end
  end
  assign take0 = side[0] < side[1] && side[0] < side[2];
  assign take1 = side[1] < side[2];
  assign sel = take0 ? 2'd0 : (take1 ? 2'd1 : 2'd2);
  logic [DIST_W:0] sum;
  assign sum = {1'b0, side[sel]} + {1'b0, delta[sel]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_item.op == OP_CAST) begin
            c[0] <= CW'(in_item.sx >>> FRAC_BITS);
            c[1] <= CW'(in_item.sy >>> FRAC_BITS);
            c[2] <= CW'(in_item.sz >>> FRAC_BITS);
            begin
              logic signed [DIR_W-1:0] d3 [3];
              logic [FRAC_BITS-1:0] f3 [3];
              d3[0] = in_item.dx; d3[1] = in_item.dy; d3[2] = in_item.dz;
              f3[0] = in_item.sx[FRAC_BITS-1:0];
              f3[1] = in_item.sy[FRAC_BITS-1:0];
              f3[2] = in_item.sz[FRAC_BITS-1:0];
              for (int i = 0; i < 3; i++) begin
                mag[i] <= d3[i] < 0 ? MAGW'(-d3[i]) : MAGW'(d3[i]);
                stp[i] <= d3[i] > 0 ? 2'sd1 : (d3[i] < 0 ? -2'sd1 : 2'sd0);
                bdist[i] <= d3[i] > 0 ? (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(f3[i])
                  : (FRAC_BITS+1)'(f3[i]);
              end
            end
            ax <= 2'd0;
            rem <= '0;
            quo <= '0;
            bit_cnt <= ($clog2(QW+1))'(QW - 1);
            face <= FACE_NORTH;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_ge ? rem_sh - QW'(mag[ax]) : rem_sh;
          quo <= {quo[QW-2:0], rem_ge};
          if (bit_cnt == 0) begin
            state <= S_MUL;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        S_MUL: begin
          if (stp[ax] == 0) begin
            delta[ax] <= DIST_MAX;
            side[ax] <= DIST_MAX;
          end else begin
            logic [DIST_W-1:0] dq;
            dq = (quo > QW'(DIST_MAX)) ? DIST_MAX : DIST_W'(quo);
            if (dq == 0) dq = DIST_W'(1);
            delta[ax] <= dq;
            side[ax] <= ((PW'(bdist[ax]) * PW'(dq)) >> FRAC_BITS) > PW'(DIST_MAX)
              ? DIST_MAX : DIST_W'((PW'(bdist[ax]) * PW'(dq)) >> FRAC_BITS);
          end
          if (ax == 2'd2) begin
            state <= S_READ;
          end else begin
            ax <= ax + 1'b1;
            rem <= '0;
            quo <= '0;
            bit_cnt <= ($clog2(QW+1))'(QW - 1);
            state <= S_DIV;
          end
        end
        S_READ: state <= S_WAIT;
        S_WAIT: state <= S_EVAL;
        S_EVAL: begin
          if (in_g && ram_rdata) begin
            found <= '{hit: 1'b1, hx: CELL_W'(c[0]), hy: CELL_W'(c[1]),
              hz: CELL_W'(c[2]), face: face};
            state <= S_DONE;
          end else if (leave || side[sel] > DIST_W'(reach)) begin
            found <= '0;
            state <= S_DONE;
          end else begin
            c[sel] <= c[sel] + CW'(stp[sel]);
            side[sel] <= sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
            unique case (sel)
              2'd0: face <= stp[0] > 0 ? FACE_WEST : FACE_EAST;
              2'd1: face <= stp[1] > 0 ? FACE_BOTTOM : FACE_TOP;
              default: face <= stp[2] > 0 ? FACE_SOUTH : FACE_NORTH;
            endcase
            state <= S_READ;
          end
        end
        S_DONE: begin
          // Hold the finished result until the output register is free.
          if (!res_valid) begin
            res <= found;
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
